FILE: design/empq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package empq_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int STEPS    = 4096;
  localparam int STEP_W   = $clog2(STEPS + 1);

  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int WEIGHT_W = 31;
  localparam int VALUE_W  = 31;
  localparam int DL_W     = 13;

  localparam logic [OP_W-1:0]   OP_IDLE    = 2'd0;
  localparam logic [OP_W-1:0]   OP_INSERT  = 2'd1;
  localparam logic [OP_W-1:0]   OP_EXTRACT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PLAIN    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRING = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REWEIGHT = 2'd2;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] later_weight;
    logic [VALUE_W-1:0]  payload;
    logic [DL_W-1:0]     deadline;
    logic [KIND_W-1:0]   kind;
    logic [STEP_W-1:0]   age;
  } slot_entry_t;

  typedef struct packed {
    logic             clear;
    logic             valid;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic             have;
    logic [IDX_W-1:0] best_idx;
    logic [VALUE_W-1:0] best_payload;
    logic             have_free;
    logic [IDX_W-1:0] free_idx;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: design/empq_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module empq_slot_ram import empq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire slot_entry_t wr_data,
  input  wire logic        rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output slot_entry_t      rd_data
);

  slot_entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/empq_select.sv
`timescale 1ns / 1ps
`default_nettype none

module empq_select import empq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire scan_ctl_t   ctl,
  input  wire logic        live,
  input  wire slot_entry_t entry,
  input  wire logic [STEP_W-1:0] step,
  output scan_res_t        res
);

  logic                occupied;
  logic                reached;
  logic [WEIGHT_W-1:0] cur_weight;
  logic                better;
  logic [WEIGHT_W-1:0] best_weight;
  logic [STEP_W-1:0]   best_age;

  // Deadline reached: step at or past the stored deadline.
  assign reached    = step >= STEP_W'(entry.deadline);
  assign occupied   = live && !(entry.kind == KIND_EXPIRING && reached);
  assign cur_weight = (entry.kind == KIND_REWEIGHT && reached) ? entry.later_weight
                                                                : entry.weight;
  // Strict compare keeps the lowest index on a full tie.
  assign better = !res.have || (cur_weight < best_weight) ||
                  (cur_weight == best_weight && entry.age < best_age);

  always_ff @(posedge clk) begin
    if (ctl.valid && occupied && better) begin
      res.best_idx     <= ctl.idx;
      res.best_payload <= entry.payload;
      best_weight      <= cur_weight;
      best_age         <= entry.age;
    end
    if (ctl.valid && !occupied && !res.have_free) begin
      res.free_idx <= ctl.idx;
    end
    if (rst || ctl.clear) begin
      res.have      <= 1'b0;
      res.have_free <= 1'b0;
    end else if (ctl.valid) begin
      if (occupied && better) begin
        res.have <= 1'b1;
      end
      if (!occupied && !res.have_free) begin
        res.have_free <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/expiring_min_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Priority queue of CAPACITY slots whose keys may expire or change over time. Every
// accepted input word is one time step. An insert scans the table for the lowest free
// slot and writes the entry there; an extract scans every slot for the live entry with
// the smallest current weight, ties going to the earliest insert, frees it and returns
// one result word. No new word is accepted while an insert or extract is in progress.
// Idle ticks, unused operation codes and inserts that are dead on arrival or carry an
// unused kind are taken without a scan and give no result. Both scans are paced by the
// single read port of the slot memory, one slot per cycle. The result sits in an output
// register, so a new input word is taken while a result waits; a finished extract waits
// only if the previous result has not been taken yet. The sticky overflow bit (an insert
// dropped on a full table) rides along with every result. Live bits reset at once, so
// the queue is usable in the first cycle after reset.
module expiring_min_priority_queue_core import empq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // weight [30:0], payload [61:31], deadline [74:62], later_weight [105:75], zero fill
  input  wire logic [111:0] s_tdata,
  // operation [1:0], kind [3:2]
  input  wire logic [3:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // result_value [30:0], zero fill
  output logic [31:0]       m_tdata,
  // found [0], overflowed [1]
  output logic [1:0]        m_tuser
);

  localparam int PAY_LO = WEIGHT_W;
  localparam int DL_LO  = PAY_LO + VALUE_W;
  localparam int LW_LO  = DL_LO + DL_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;

  // Captured input word.
  logic [OP_W-1:0]     item_op;
  logic [KIND_W-1:0]   item_kind;
  logic [WEIGHT_W-1:0] item_weight;
  logic [VALUE_W-1:0]  item_payload;
  logic [DL_W-1:0]     item_deadline;
  logic [WEIGHT_W-1:0] item_later;
  logic [STEP_W-1:0]   item_step;

  logic [STEP_W-1:0]   step_count;
  logic                overflow_flag;
  logic [CAPACITY-1:0] live;

  // Scan pipeline: issue address, then compare in the next cycle.
  logic                rd_issue;
  logic [IDX_W-1:0]    rd_addr;
  logic                rd_pending;
  logic [IDX_W-1:0]    rd_idx;
  logic                live_rd;
  slot_entry_t         rd_data;

  logic                accept;
  logic                in_dead;
  logic                in_scan;
  logic                out_free;
  logic                wr_en;
  slot_entry_t         wr_data;
  scan_ctl_t           ctl;
  scan_res_t           res;

  logic [OP_W-1:0]     in_op;
  logic [KIND_W-1:0]   in_kind;
  logic [DL_W-1:0]     in_deadline;

  assign in_op       = s_tuser[1:0];
  assign in_kind     = s_tuser[3:2];
  assign in_deadline = s_tdata[DL_LO +: DL_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Expiring or reweighting entries whose deadline is already reached or passed vanish.
  assign in_dead = (in_kind != KIND_PLAIN) && (STEP_W'(in_deadline) <= step_count);
  always_comb begin
    unique case (in_op)
      OP_INSERT:  in_scan = (in_kind == KIND_PLAIN || in_kind == KIND_EXPIRING ||
                             in_kind == KIND_REWEIGHT) && !in_dead;
      OP_EXTRACT: in_scan = 1'b1;
      default:    in_scan = 1'b0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step_count    <= '0;
      overflow_flag <= 1'b0;
      rd_issue      <= 1'b0;
      rd_pending    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // Drop the taken result unless a new one is loaded at this edge.
      if (m_tvalid && m_tready && !(state == ST_FINISH && item_op != OP_INSERT)) begin
        m_tvalid <= 1'b0;
      end
      rd_pending <= rd_issue;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // Saturate the step counter at STEPS.
            if (step_count < STEP_W'(STEPS)) begin
              step_count <= step_count + STEP_W'(1);
            end
            if (in_scan) begin
              state    <= ST_SCAN;
              rd_issue <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (rd_issue && rd_addr == LAST_IDX) begin
            rd_issue <= 1'b0;
          end
          if (rd_pending && rd_idx == LAST_IDX) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (item_op == OP_INSERT) begin
            if (!res.have_free) begin
              overflow_flag <= 1'b1;
            end
            state <= ST_IDLE;
          end else if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the input word and step for the whole scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op       <= in_op;
      item_kind     <= in_kind;
      item_weight   <= s_tdata[0 +: WEIGHT_W];
      item_payload  <= s_tdata[PAY_LO +: VALUE_W];
      item_deadline <= in_deadline;
      item_later    <= s_tdata[LW_LO +: WEIGHT_W];
      item_step     <= step_count;
    end
  end

  // Advance the read address; the memory and live bit answer in the next cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr <= '0;
    end else if (rd_issue) begin
      rd_addr <= rd_addr + IDX_W'(1);
    end
    rd_idx <= rd_addr;
    if (rd_issue) begin
      live_rd <= live[rd_addr];
    end
  end

  // Load the result word once the extract scan is done.
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && item_op != OP_INSERT && out_free) begin
      m_tdata <= {1'b0, res.have ? res.best_payload : VALUE_W'(0)};
      m_tuser <= {overflow_flag, res.have};
    end
  end

  // Live bits: set on a placed insert, drop on extract. Reads and writes never share
  // a cycle, since writes only happen after the scan has drained.
  assign wr_en = (state == ST_FINISH) && (item_op == OP_INSERT) && res.have_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (wr_en) begin
      live[res.free_idx] <= 1'b1;
    end else if (state == ST_FINISH && item_op != OP_INSERT && out_free && res.have) begin
      live[res.best_idx] <= 1'b0;
    end
  end

  always_comb begin
    wr_data.weight       = item_weight;
    wr_data.later_weight = item_later;
    wr_data.payload      = item_payload;
    wr_data.deadline     = item_deadline;
    wr_data.kind         = item_kind;
    wr_data.age          = item_step;
  end

  assign ctl = '{clear: accept, valid: rd_pending, idx: rd_idx};

  empq_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (res.free_idx),
    .wr_data (wr_data),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  empq_select u_select (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .live  (live_rd),
    .entry (rd_data),
    .step  (item_step),
    .res   (res)
  );

  // A new result only comes out of the finish state.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINISH)
    else $error("result word raised outside finish");

  // The last compare of a scan hands over to the finish state.
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && rd_pending && rd_idx == LAST_IDX) |=> state == ST_FINISH)
    else $error("scan did not finish");

  // The chosen minimum is always a live slot.
  a_best_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && item_op == OP_EXTRACT && res.have) |-> live[res.best_idx])
    else $error("extract picked a slot that is not live");

  // Step counter never passes its saturation point.
  a_step_sat: assert property (@(posedge clk) disable iff (rst)
    step_count <= STEP_W'(STEPS))
    else $error("step counter past saturation");

  // No memory read is issued while the table is being written.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !rd_issue && !rd_pending)
    else $error("slot write overlaps a scan read");

endmodule

`default_nettype wire

FILE: dv/empq_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the queue core, keeps a shadow of the slot table, and
// checks every result word against the oldest predicted extract.
module empq_checker import empq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  // weight [30:0], payload [61:31], deadline [74:62], later_weight [105:75], zero fill
  input  wire logic [111:0] s_tdata,
  // operation [1:0], kind [3:2]
  input  wire logic [3:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  // result_value [30:0], zero fill
  input  wire logic [31:0]  m_tdata,
  // found [0], overflowed [1]
  input  wire logic [1:0]   m_tuser,
  output int                errors,
  output int                pending,
  output int                hits,
  output int                misses,
  output logic              overflow_seen
);

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] value;
    logic               overflowed;
  } extract_result_t;

  logic                q_live     [CAPACITY];
  logic [WEIGHT_W-1:0] q_weight   [CAPACITY];
  logic [WEIGHT_W-1:0] q_later    [CAPACITY];
  logic [VALUE_W-1:0]  q_payload  [CAPACITY];
  logic [DL_W-1:0]     q_deadline [CAPACITY];
  logic [KIND_W-1:0]   q_kind     [CAPACITY];
  logic [STEP_W-1:0]   q_age      [CAPACITY];

  logic [STEP_W-1:0]   step_now   = '0;
  logic                sticky_ovf = 1'b0;
  logic                ovf_seen   = 1'b0;
  extract_result_t     extract_q[$];
  int                  error_cnt   = 0;
  int                  pending_cnt = 0;
  int                  hit_cnt     = 0;
  int                  miss_cnt    = 0;

  assign errors        = error_cnt;
  assign pending       = pending_cnt;
  assign hits          = hit_cnt;
  assign misses        = miss_cnt;
  assign overflow_seen = ovf_seen;

  // An expiring slot past its deadline counts as free.
  function automatic logic slot_taken(int k, logic [STEP_W-1:0] s);
    return q_live[k] && !(q_kind[k] == KIND_EXPIRING && s >= q_deadline[k]);
  endfunction

  function automatic logic [WEIGHT_W-1:0] key_at(int k, logic [STEP_W-1:0] s);
    if (q_kind[k] == KIND_REWEIGHT && s >= q_deadline[k])
      return q_later[k];
    return q_weight[k];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_cnt++;
    $display("%0t ERROR %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Apply one accepted word to the shadow table; an extract queues its result.
  task automatic advance_queue(logic [OP_W-1:0] op, logic [KIND_W-1:0] kind,
                               logic [WEIGHT_W-1:0] w, logic [VALUE_W-1:0] v,
                               logic [DL_W-1:0] dl, logic [WEIGHT_W-1:0] lw);
    int                  k;
    int                  best;
    logic [WEIGHT_W-1:0] key;
    logic [WEIGHT_W-1:0] best_key;
    extract_result_t     res;
    best     = -1;
    best_key = '0;
    if (op == OP_INSERT && kind <= KIND_REWEIGHT) begin
      // drop timed entries whose deadline has already come
      if (kind == KIND_PLAIN || dl > step_now) begin
        k = 0;
        while (k < CAPACITY && slot_taken(k, step_now))
          k++;
        if (k == CAPACITY) begin
          sticky_ovf = 1'b1;
        end else begin
          q_live[k]     = 1'b1;
          q_weight[k]   = w;
          q_later[k]    = lw;
          q_payload[k]  = v;
          q_deadline[k] = dl;
          q_kind[k]     = kind;
          q_age[k]      = step_now;
        end
      end
    end else if (op == OP_EXTRACT) begin
      // ascending scan with strict compares keeps the lowest slot on a full tie
      for (k = 0; k < CAPACITY; k++) begin
        if (slot_taken(k, step_now)) begin
          key = key_at(k, step_now);
          if (best < 0 || key < best_key || (key == best_key && q_age[k] < q_age[best])) begin
            best     = k;
            best_key = key;
          end
        end
      end
      res.found      = (best >= 0);
      res.value      = (best >= 0) ? q_payload[best] : '0;
      res.overflowed = sticky_ovf;
      if (best >= 0)
        q_live[best] = 1'b0;
      extract_q.insert(extract_q.size(), res);
    end
    if (step_now < STEPS)
      step_now++;
  endtask

  always @(posedge clk) begin
    extract_result_t want;
    if (rst) begin
      for (int k = 0; k < CAPACITY; k++)
        q_live[k] = 1'b0;
      step_now   = '0;
      sticky_ovf = 1'b0;
      extract_q.delete();
    end else begin
      // check the outgoing word first: it can never belong to this edge's input
      if (m_tvalid && m_tready) begin
        if (m_tuser[1] === 1'b1)
          ovf_seen = 1'b1;
        if (extract_q.size() == 0) begin
          report_mismatch("result word with nothing expected", '0, m_tdata);
        end else begin
          want = extract_q.pop_front();
          if (want.found) hit_cnt++;
          else miss_cnt++;
          if (m_tuser[0] !== want.found)
            report_mismatch("found", 32'(want.found), 32'(m_tuser[0]));
          if (m_tdata[VALUE_W-1:0] !== want.value)
            report_mismatch("result_value", 32'(want.value), 32'(m_tdata[VALUE_W-1:0]));
          if (m_tuser[1] !== want.overflowed)
            report_mismatch("overflowed", 32'(want.overflowed), 32'(m_tuser[1]));
          if (m_tdata[31] !== 1'b0)
            report_mismatch("tdata fill bit", '0, 32'(m_tdata[31]));
        end
      end
      if (s_tvalid && s_tready)
        advance_queue(s_tuser[1:0], s_tuser[3:2], s_tdata[30:0], s_tdata[61:31],
                      s_tdata[74:62], s_tdata[105:75]);
    end
    pending_cnt = extract_q.size();
  end

endmodule

FILE: dv/tb_expiring_min_priority_queue_core.sv
`timescale 1ns / 1ps

module tb_expiring_min_priority_queue_core;
  import empq_pkg::*;

  // Codes the block must treat as no-ops.
  localparam logic [OP_W-1:0]   OP_SPARE   = 2'd3;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata  = '0;
  logic [3:0]   s_tuser  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;
  logic [1:0]   m_tuser;

  int   errors;
  int   pending;
  int   hits;
  int   misses;
  logic overflow_seen;

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                words_sent    = 0;
  logic [STEP_W-1:0] step_now      = '0;

  expiring_min_priority_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  empq_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .errors        (errors),
    .pending       (pending),
    .hits          (hits),
    .misses        (misses),
    .overflow_seen (overflow_seen)
  );

  always #5 clk = ~clk;

  // Hard stop, many times the slowest legal run.
  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: stall the result channel at the current rate.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one word, with random gaps ahead of it, and hold it until taken.
  // Leave tvalid high on return so back-to-back words need no extra edge.
  task automatic send_word(logic [OP_W-1:0] op, logic [KIND_W-1:0] kind,
                           int unsigned w, int unsigned v,
                           int unsigned dl, int unsigned lw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {kind, op};
    s_tdata  <= {6'd0, lw[WEIGHT_W-1:0], dl[DL_W-1:0], v[VALUE_W-1:0], w[WEIGHT_W-1:0]};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    words_sent++;
    if (step_now < STEPS)
      step_now++;
  endtask

  // Drop tvalid, then switch idling rates away from the clock edge.
  task automatic set_idling(int send_pct, int recv_pct);
    s_tvalid <= 1'b0;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(posedge clk);
  endtask

  // Many small keys so that ties come up often; extremes now and then.
  function automatic int unsigned pick_weight();
    int unsigned r;
    int unsigned w;
    r = $urandom_range(99);
    if (r < 40)      w = $urandom_range(15);
    else if (r < 45) w = 0;
    else if (r < 50) w = 32'h7FFF_FFFF;
    else             w = $urandom;
    return w;
  endfunction

  // Mostly deadlines just ahead, so entries expire and switch keys during the run.
  function automatic int unsigned pick_deadline();
    int unsigned r;
    int unsigned d;
    r = $urandom_range(99);
    if (r < 45)      d = step_now + $urandom_range(40);
    else if (r < 60) d = step_now - $urandom_range(3);
    else if (r < 70) d = STEPS;
    else             d = $urandom;
    return d;
  endfunction

  task automatic random_word(int insert_pct, int extract_pct);
    int unsigned       r;
    logic [KIND_W-1:0] kind;
    r    = $urandom_range(99);
    kind = KIND_W'($urandom_range(2));
    if ($urandom_range(99) < 4)
      kind = KIND_SPARE;
    if (r < insert_pct)
      send_word(OP_INSERT, kind, pick_weight(), $urandom, pick_deadline(), pick_weight());
    else if (r < insert_pct + extract_pct)
      send_word(OP_EXTRACT, KIND_W'($urandom), $urandom, $urandom, $urandom, $urandom);
    else
      send_word(($urandom_range(1) != 0) ? OP_SPARE : OP_IDLE,
                KIND_W'($urandom), $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [KIND_W-1:0] fill_kind;
    int unsigned       fill_dl;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sender mostly busy, receiver mostly stalled.
    set_idling(18, 78);

    // Directed words; the comment gives the step each one works at.
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 0: empty table
    send_word(OP_INSERT, KIND_PLAIN, '0, '1, '0, '1);           // 1: lightest key
    send_word(OP_INSERT, KIND_PLAIN, '1, '0, '1, '0);           // 2: heaviest key
    send_word(OP_INSERT, KIND_EXPIRING, 1, 11, 3, 0);           // 3: deadline now, dead
    send_word(OP_INSERT, KIND_REWEIGHT, 1, 12, 0, 0);           // 4: deadline past, dead
    send_word(OP_INSERT, KIND_SPARE, 0, 13, '1, 0);             // 5: unused kind, no store
    send_word(OP_SPARE, KIND_SPARE, '1, '1, '1, '1);            // 6: unused op, idle tick
    send_word(OP_IDLE, KIND_SPARE, '1, '1, '1, '1);             // 7: idle with all ones
    send_word(OP_INSERT, KIND_EXPIRING, 5, 21, 12, 0);          // 8: lives through 11
    send_word(OP_INSERT, KIND_REWEIGHT, 100, 22, 11, 2);        // 9: key 2 from step 11
    send_word(OP_INSERT, KIND_PLAIN, 5, 23, 0, 0);              // 10: ties with step 8
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 11: lightest key
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 12: switched key wins
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 13: expired one skipped
    send_word(OP_INSERT, KIND_EXPIRING, 7, 31, 16, 0);          // 14
    send_word(OP_INSERT, KIND_PLAIN, 7, 32, 0, 0);              // 15
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 16: just expired
    send_word(OP_INSERT, KIND_PLAIN, 9, 41, 0, 0);              // 17: reuses expired slot
    send_word(OP_INSERT, KIND_PLAIN, 9, 42, 0, 0);              // 18
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 19: tie, older wins
    send_word(OP_INSERT, KIND_PLAIN, 9, 43, 0, 0);              // 20: newer in lower slot
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 21: age beats slot index
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 22
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 23: heaviest key
    send_word(OP_EXTRACT, KIND_PLAIN, '0, '0, '0, '0);          // 24: empty again

    repeat (300)
      random_word(45, 40);

    // Sender mostly idle, receiver mostly ready.
    set_idling(78, 18);

    // Fill past capacity with entries that cannot expire, to force the overflow.
    repeat (270) begin
      fill_kind = ($urandom_range(3) == 0) ? KIND_REWEIGHT : KIND_PLAIN;
      fill_dl   = step_now + 1 + $urandom_range(200);
      send_word(OP_INSERT, fill_kind, pick_weight(), $urandom, fill_dl, pick_weight());
    end
    repeat (80)
      random_word(45, 45);

    // No idling on either side.
    set_idling(0, 0);

    repeat (300)
      random_word(40, 50);

    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
    // give a stray result time to show up
    repeat (CAPACITY + 16) @(posedge clk);

    $display("Summary: %0d words sent, %0d extract results checked (%0d hits, %0d empty)",
             words_sent, hits + misses, hits, misses);
    $display("Summary: overflow flag seen = %0b, step counter ended at %0d",
             overflow_seen, step_now);
    if (errors == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: expiring_min_priority_queue_core.f
design/empq_pkg.sv
design/empq_slot_ram.sv
design/empq_select.sv
design/expiring_min_priority_queue_core.sv
dv/empq_checker.sv
dv/tb_expiring_min_priority_queue_core.sv
